>>> sv/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expects signals named clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CLP_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define CLP_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> sv/clp_pkg.sv
// Shared types and constants of the crossfading loop player.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none
package clp_pkg;

  localparam int NUM_VOICES_DEF   = 4;
  localparam int SAMPLE_DEPTH_DEF = 65536;
  localparam int CHANNELS_DEF     = 2;

  localparam int SAMPLE_W = 24;
  localparam int LEN_W    = 12;
  localparam int GAIN_W   = 16;
  localparam int POS_W    = 16;
  localparam int CFG_W    = 16;
  localparam int DIV_W    = 40;
  localparam int VAL_W    = 26;

  localparam logic [LEN_W-1:0]  LEN_RESET  = 12'd480;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;

  localparam logic CFG_LEN  = 1'b0;
  localparam logic CFG_GAIN = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_RANGE  = 2'd2,
    OP_SELECT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_OFF      = 2'd0,
    MODE_FADE_IN  = 2'd1,
    MODE_ACTIVE   = 2'd2,
    MODE_FADE_OUT = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_VOICE, S_RDH, S_RDT, S_CHAN, S_SEAM, S_MUL1, S_MUL2,
    S_NUM, S_DIV, S_DIVQ, S_UPD, S_OUT
  } state_t;

endpackage
`default_nettype wire

>>> sv/clp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module clp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/crossfading_loop_player_unit.sv
// Crossfading loop player: sample RAM, voice state and the mixing sequencer.
// Depends on clp_pkg and clp_ram.
//
// Channel | Signals                                              | Direction
// in      | in_valid, in_stall, operation .. play_on             | in
// out     | out_valid, out_stall, out_left, out_right            | out
// cfg     | cfg_write, cfg_index, cfg_data                       | in
//
// Write, range set and select never stall the input. A tick stalls the input
// while every voice is visited: a silent voice is skipped, and each voice that
// sounds goes once per channel through the 1-bit-per-cycle divider by the
// crossfade length, and once more per channel on the loop seam. Reset is
// synchronous; the sample RAM is not cleared.
// A finished frame waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none
module crossfading_loop_player_unit import clp_pkg::*; #(
  parameter int NUM_VOICES   = NUM_VOICES_DEF,
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
  parameter int CHANNELS     = CHANNELS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 operation,
  input  wire logic [15:0]                address,
  input  wire logic signed [SAMPLE_W-1:0] write_left,
  input  wire logic signed [SAMPLE_W-1:0] write_right,
  input  wire logic [1:0]                 voice_index,
  input  wire logic [POS_W-1:0]           range_a,
  input  wire logic [POS_W-1:0]           range_b,
  input  wire logic                       play_on,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [SAMPLE_W-1:0]      out_left,
  output logic signed [SAMPLE_W-1:0]      out_right,
  input  wire logic                       cfg_write,
  input  wire logic                       cfg_index,
  input  wire logic [CFG_W-1:0]           cfg_data
);
  localparam int VI_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
  localparam int RAM_W  = SAMPLE_W * CHANNELS;
  localparam int ACC_W  = VAL_W + $clog2(NUM_VOICES) + 1;
  localparam int DC_W   = $clog2(DIV_W);

  // Configuration and voice state.
  logic [LEN_W-1:0]  crossfade_len;
  logic [GAIN_W-1:0] voice_gain;
  mode_t             voice_mode    [NUM_VOICES];
  logic [LEN_W-1:0]  fade_count    [NUM_VOICES];
  logic [POS_W-1:0]  play_position [NUM_VOICES];
  logic              first_pass    [NUM_VOICES];
  logic [POS_W-1:0]  loop_start    [NUM_VOICES];
  logic [POS_W-1:0]  loop_end      [NUM_VOICES];

  state_t state, state_next;
  logic [VI_W-1:0] vi;
  logic            ch;
  logic signed [ACC_W-1:0] acc [2];

  // Per-voice latched values.
  logic [POS_W-1:0] pos_c, tail_addr;
  logic [LEN_W-1:0] kk, lmk, env;
  logic             seam;
  logic [RAM_W-1:0] head, tail;
  logic signed [SAMPLE_W-1:0] x_smp;
  logic signed [36:0] p1, p2;
  logic signed [40:0] m1;
  logic signed [53:0] m2;

  // Divider.
  logic [DIV_W-1:0] dquo;
  logic [LEN_W-1:0] drem;
  logic             dneg, dseam;
  logic [DC_W-1:0]  dcnt;

  logic [LEN_W-1:0] len;
  assign len = (crossfade_len == '0) ? LEN_W'(1) : crossfade_len;

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Current voice view.
  logic [POS_W-1:0] cur_start, cur_end, span, pos_cl, k_full;
  logic [LEN_W:0]   two_len;
  logic             cur_skip, cur_seam, last_voice, last_ch;
  logic [LEN_W-1:0] cur_cnt, cur_env;
  always_comb begin
    cur_start = loop_start[vi];
    cur_end   = loop_end[vi];
    span      = cur_end - cur_start;
    two_len   = {len, 1'b0};
    cur_skip  = (voice_mode[vi] == MODE_OFF) || (cur_end < cur_start) ||
                ({1'b0, span} < 17'(two_len));
    pos_cl = play_position[vi];
    if (pos_cl < cur_start) begin
      pos_cl = cur_start;
    end
    if (pos_cl > cur_end - 16'd1) begin
      pos_cl = cur_end - 16'd1;
    end
    k_full   = pos_cl - cur_start;
    cur_seam = !first_pass[vi] && (k_full < POS_W'(len));
    cur_cnt  = (fade_count[vi] > len) ? len : fade_count[vi];
    unique case (voice_mode[vi])
      MODE_FADE_IN:  cur_env = cur_cnt;
      MODE_FADE_OUT: cur_env = len - cur_cnt;
      default:       cur_env = len;
    endcase
    last_voice = (vi == VI_W'(NUM_VOICES - 1));
    last_ch    = (CHANNELS < 2) || ch;
  end

  // Sample RAM.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata, rd_data;
  logic [POS_W-1:0]  rd_addr;
  logic              rd_oob, rd_oob_q;

  assign ram_we    = accept && (op_t'(operation) == OP_WRITE) &&
                     (32'(address) < SAMPLE_DEPTH);
  assign ram_waddr = ADDR_W'(32'(address));
  assign ram_wdata = (CHANNELS > 1) ? RAM_W'({write_right, write_left})
                                    : RAM_W'(write_left);
  assign rd_addr   = (state == S_VOICE) ? pos_cl : tail_addr;
  assign ram_raddr = ADDR_W'(32'(rd_addr));
  assign rd_oob    = 32'(rd_addr) >= SAMPLE_DEPTH;
  assign rd_data   = rd_oob_q ? '0 : ram_rdata;

  clp_ram #(.WIDTH(RAM_W), .DEPTH(SAMPLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Divider step and result: floor division of a signed value by len.
  logic [LEN_W:0]    rem_sh;
  logic              dge;
  logic [DIV_W:0]    qmag;
  logic signed [DIV_W:0] qval;
  always_comb begin
    rem_sh = {drem, dquo[DIV_W-1]};
    dge    = rem_sh >= {1'b0, len};
    qmag   = {1'b0, dquo};
    qval   = dneg ? $signed(-qmag - ((drem != '0) ? (DIV_W+1)'(1) : '0))
                  : $signed(qmag);
  end

  logic signed [DIV_W-1:0] seam_num, fin_num;
  logic signed [SAMPLE_W-1:0] head_ch, tail_ch;
  always_comb begin
    head_ch  = head[ch*SAMPLE_W +: SAMPLE_W];
    tail_ch  = tail[ch*SAMPLE_W +: SAMPLE_W];
    seam_num = DIV_W'(p1 + p2 + $signed({26'd0, len[LEN_W-1:1]}));
    fin_num  = DIV_W'((m2 + $signed({28'd0, len, 14'd0})) >>> 15);
  end

  function automatic logic signed [SAMPLE_W-1:0] sat24(
      input logic signed [ACC_W-1:0] a);
    if (a > $signed(ACC_W'(8388607))) begin
      return 24'sd8388607;
    end else if (a < -$signed(ACC_W'(8388608))) begin
      return -24'sd8388608;
    end
    return SAMPLE_W'(a);
  endfunction

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept && op_t'(operation) == OP_TICK) state_next = S_VOICE;
      S_VOICE: begin
        if (!cur_skip) begin
          state_next = S_RDH;
        end else if (last_voice) begin
          state_next = S_OUT;
        end
      end
      S_RDH:   state_next = seam ? S_RDT : S_CHAN;
      S_RDT:   state_next = S_CHAN;
      S_CHAN:  state_next = seam ? S_SEAM : S_MUL1;
      S_SEAM:  state_next = S_DIV;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_NUM;
      S_NUM:   state_next = S_DIV;
      S_DIV:   if (dcnt == DC_W'(DIV_W - 1)) state_next = S_DIVQ;
      S_DIVQ: begin
        if (dseam) begin
          state_next = S_MUL1;
        end else begin
          state_next = last_ch ? S_UPD : S_CHAN;
        end
      end
      S_UPD:   state_next = last_voice ? S_OUT : S_VOICE;
      S_OUT:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath without reset.
  always_ff @(posedge clk) begin
    rd_oob_q <= rd_oob;
    unique case (state)
      S_VOICE: begin
        pos_c     <= pos_cl;
        kk        <= k_full[LEN_W-1:0];
        lmk       <= len - k_full[LEN_W-1:0];
        seam      <= cur_seam;
        env       <= cur_env;
        tail_addr <= cur_end - POS_W'(len) + k_full;
        ch        <= 1'b0;
      end
      S_RDH: head <= rd_data;
      S_RDT: tail <= rd_data;
      S_CHAN: begin
        x_smp <= head_ch;
        p1    <= head_ch * $signed({1'b0, kk});
        p2    <= tail_ch * $signed({1'b0, lmk});
      end
      S_SEAM, S_NUM: begin
        dneg  <= (state == S_SEAM) ? seam_num[DIV_W-1] : fin_num[DIV_W-1];
        dquo  <= (state == S_SEAM)
                 ? (seam_num[DIV_W-1] ? DIV_W'(-seam_num) : DIV_W'(seam_num))
                 : (fin_num[DIV_W-1] ? DIV_W'(-fin_num) : DIV_W'(fin_num));
        drem  <= '0;
        dcnt  <= '0;
        dseam <= (state == S_SEAM);
      end
      S_MUL1: m1 <= x_smp * $signed({1'b0, voice_gain});
      S_MUL2: m2 <= m1 * $signed({1'b0, env});
      S_DIV: begin
        drem <= dge ? LEN_W'(rem_sh - {1'b0, len}) : LEN_W'(rem_sh);
        dquo <= {dquo[DIV_W-2:0], dge};
        dcnt <= dcnt + DC_W'(1);
      end
      S_DIVQ: begin
        if (dseam) begin
          // A seam blend stays within the sample range.
          x_smp <= SAMPLE_W'(qval);
          dseam <= 1'b0;
        end else begin
          acc[ch] <= acc[ch] + ACC_W'(qval);
          if (!last_ch) begin
            ch <= 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (accept && op_t'(operation) == OP_TICK) begin
      acc[0] <= '0;
      acc[1] <= '0;
    end
  end

  // Control and voice state.
  logic [LEN_W-1:0] new_len;
  logic [LEN_W:0]   upd_cnt;
  logic [POS_W:0]   upd_pos;
  assign new_len = (cfg_data[LEN_W-1:0] == '0) ? LEN_W'(1) : cfg_data[LEN_W-1:0];
  assign upd_cnt = {1'b0, ((fade_count[vi] > len) ? len : fade_count[vi])} + 13'd1;
  assign upd_pos = {1'b0, pos_c} + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crossfade_len <= LEN_RESET;
      voice_gain    <= GAIN_RESET;
      vi            <= '0;
      out_valid     <= 1'b0;
      for (int v = 0; v < NUM_VOICES; v++) begin
        voice_mode[v]    <= MODE_OFF;
        fade_count[v]    <= '0;
        play_position[v] <= '0;
        first_pass[v]    <= 1'b1;
        loop_start[v]    <= '0;
        loop_end[v]      <= '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        if (cfg_index == CFG_LEN) begin
          crossfade_len <= cfg_data[LEN_W-1:0];
          for (int v = 0; v < NUM_VOICES; v++) begin
            if (fade_count[v] > new_len) begin
              fade_count[v] <= new_len;
            end
          end
        end else begin
          voice_gain <= cfg_data[GAIN_W-1:0];
        end
      end
      if (accept) begin
        vi <= '0;
        unique case (op_t'(operation))
          OP_RANGE: begin
            if (32'(voice_index) < NUM_VOICES) begin
              loop_start[VI_W'(voice_index)] <= (range_a < range_b) ? range_a : range_b;
              loop_end[VI_W'(voice_index)]   <= (range_a < range_b) ? range_b : range_a;
            end
          end
          OP_SELECT: begin
            for (int v = 0; v < NUM_VOICES; v++) begin
              if (play_on && 32'(voice_index) == v) begin
                if (voice_mode[v] == MODE_FADE_OUT) begin
                  voice_mode[v] <= MODE_FADE_IN;
                  fade_count[v] <= len - ((fade_count[v] > len) ? len : fade_count[v]);
                  first_pass[v] <= 1'b1;
                end else if (voice_mode[v] == MODE_OFF) begin
                  voice_mode[v] <= MODE_FADE_IN;
                  fade_count[v] <= '0;
                  first_pass[v] <= 1'b1;
                end
              end else begin
                if (voice_mode[v] == MODE_FADE_IN) begin
                  voice_mode[v] <= MODE_FADE_OUT;
                  fade_count[v] <= len - ((fade_count[v] > len) ? len : fade_count[v]);
                end else if (voice_mode[v] == MODE_ACTIVE) begin
                  voice_mode[v] <= MODE_FADE_OUT;
                  fade_count[v] <= '0;
                end
              end
            end
          end
          default: ;
        endcase
      end
      if (state == S_VOICE && cur_skip && !last_voice) begin
        vi <= vi + VI_W'(1);
      end
      if (state == S_UPD) begin
        if (voice_mode[vi] == MODE_FADE_IN || voice_mode[vi] == MODE_FADE_OUT) begin
          if (upd_cnt >= {1'b0, len}) begin
            fade_count[vi] <= len;
            voice_mode[vi] <= (voice_mode[vi] == MODE_FADE_IN) ? MODE_ACTIVE : MODE_OFF;
          end else begin
            fade_count[vi] <= LEN_W'(upd_cnt);
          end
        end
        if (upd_pos >= {1'b0, loop_end[vi]}) begin
          play_position[vi] <= loop_start[vi];
          first_pass[vi]    <= 1'b0;
        end else begin
          play_position[vi] <= POS_W'(upd_pos);
        end
        if (!last_voice) begin
          vi <= vi + VI_W'(1);
        end
      end
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_left  <= sat24(acc[0]);
      out_right <= (CHANNELS > 1) ? sat24(acc[1]) : sat24(acc[0]);
    end
  end
endmodule
`default_nettype wire

>>> sv/clp_checker.sv
// Port-level checks of the crossfading loop player, bound to the top level.
// Depends on clp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module clp_checker import clp_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic [1:0]          operation,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [SAMPLE_W-1:0] out_left,
  input wire logic [SAMPLE_W-1:0] out_right
);
  // A tick keeps the input side busy while the frame is mixed.
  `CLP_ASSERT_NXT(a_tick_busy, in_valid && !in_stall && operation == OP_TICK, in_stall)
  // A new frame only appears at the end of a mixing run.
  `CLP_ASSERT_IMP(a_frame_after_run, $rose(out_valid), $past(in_stall))
  // A stalled frame holds.
  `CLP_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                  out_valid && $stable(out_left) && $stable(out_right))
endmodule

bind crossfading_loop_player_unit clp_checker u_clp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .operation (operation),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_left  (out_left),
  .out_right (out_right)
);
`default_nettype wire

>>> tb/crossfading_loop_player_unit_tb.sv
// Self-checking testbench for the crossfading loop player.
// Depends on clp_pkg and crossfading_loop_player_unit; drives random and directed items.
`timescale 1ns / 1ps

class loop_mix_scoreboard;
  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } frame_t;

  logic signed [23:0] mem_left[65536];
  logic signed [23:0] mem_right[65536];
  clp_pkg::mode_t mode[4];
  int unsigned fade_cnt[4];
  int unsigned play_pos[4];
  bit first_pass[4];
  int unsigned lstart[4];
  int unsigned lend[4];
  int unsigned xfade_len;
  int unsigned gain;
  frame_t frames_due[$];
  int errors;

  function new();
    for (int v = 0; v < 4; v++) begin
      mode[v] = clp_pkg::MODE_OFF;
      fade_cnt[v] = 0;
      play_pos[v] = 0;
      first_pass[v] = 1;
      lstart[v] = 0;
      lend[v] = 0;
    end
    xfade_len = 480;
    gain = 32768;
    errors = 0;
  endfunction

  function int unsigned eff_len();
    return (xfade_len == 0) ? 1 : xfade_len;
  endfunction

  // Nearest, halves toward plus infinity.
  function longint round_div(longint n, longint d);
    longint nn;
    longint dd;
    longint q;
    nn = 2 * n + d;
    dd = 2 * d;
    q = nn / dd;
    if ((nn % dd) != 0 && nn < 0) q--;
    return q;
  endfunction

  function void write_reg(logic idx, logic [15:0] data);
    if (idx == clp_pkg::CFG_LEN) begin
      xfade_len = data[11:0];
      for (int v = 0; v < 4; v++)
        if (fade_cnt[v] > eff_len()) fade_cnt[v] = eff_len();
    end else begin
      gain = data;
    end
  endfunction

  function void mix_voice(int v, inout longint acc_l, inout longint acc_r);
    int unsigned len;
    int unsigned p;
    int unsigned k;
    int unsigned e;
    int unsigned c;
    bit seam;
    longint xl;
    longint xr;
    len = eff_len();
    if (lend[v] < lstart[v] || lend[v] - lstart[v] < 2 * len) return;
    p = play_pos[v];
    if (p < lstart[v]) p = lstart[v];
    if (p > lend[v] - 1) p = lend[v] - 1;
    k = p - lstart[v];
    seam = !first_pass[v] && (k < len);
    c = (fade_cnt[v] > len) ? len : fade_cnt[v];
    if (mode[v] == clp_pkg::MODE_FADE_IN) e = c;
    else if (mode[v] == clp_pkg::MODE_FADE_OUT) e = len - c;
    else e = len;
    xl = mem_left[p];
    xr = mem_right[p];
    if (seam) begin
      xl = round_div(xl * k + longint'(mem_left[lend[v] - len + k]) * (len - k), len);
      xr = round_div(xr * k + longint'(mem_right[lend[v] - len + k]) * (len - k), len);
    end
    acc_l += round_div(xl * gain * e, longint'(32768) * len);
    acc_r += round_div(xr * gain * e, longint'(32768) * len);
    if (mode[v] == clp_pkg::MODE_FADE_IN || mode[v] == clp_pkg::MODE_FADE_OUT) begin
      c++;
      if (c >= len) begin
        c = len;
        mode[v] = (mode[v] == clp_pkg::MODE_FADE_IN) ? clp_pkg::MODE_ACTIVE
                                                     : clp_pkg::MODE_OFF;
      end
      fade_cnt[v] = c;
    end
    p++;
    if (p >= lend[v]) begin
      p = lstart[v];
      first_pass[v] = 0;
    end
    play_pos[v] = p;
  endfunction

  function longint sat24(longint x);
    if (x > 8388607) return 8388607;
    if (x < -8388608) return -8388608;
    return x;
  endfunction

  // Called once per accepted input transfer.
  function void note_item(logic [1:0] op, logic [15:0] addr, logic signed [23:0] wl,
                          logic signed [23:0] wr, logic [1:0] vi, logic [15:0] ra,
                          logic [15:0] rb, logic po);
    int unsigned len;
    int unsigned c;
    longint acc_l;
    longint acc_r;
    frame_t f;
    len = eff_len();
    case (op)
      clp_pkg::OP_WRITE: begin
        mem_left[addr] = wl;
        mem_right[addr] = wr;
      end
      clp_pkg::OP_RANGE: begin
        lstart[vi] = (ra < rb) ? ra : rb;
        lend[vi] = (ra < rb) ? rb : ra;
      end
      clp_pkg::OP_SELECT: begin
        for (int v = 0; v < 4; v++) begin
          c = (fade_cnt[v] > len) ? len : fade_cnt[v];
          if (po && v == vi) begin
            if (mode[v] == clp_pkg::MODE_FADE_OUT) begin
              mode[v] = clp_pkg::MODE_FADE_IN;
              fade_cnt[v] = len - c;
              first_pass[v] = 1;
            end else if (mode[v] == clp_pkg::MODE_OFF) begin
              mode[v] = clp_pkg::MODE_FADE_IN;
              fade_cnt[v] = 0;
              first_pass[v] = 1;
            end
          end else if (mode[v] == clp_pkg::MODE_FADE_IN) begin
            mode[v] = clp_pkg::MODE_FADE_OUT;
            fade_cnt[v] = len - c;
          end else if (mode[v] == clp_pkg::MODE_ACTIVE) begin
            mode[v] = clp_pkg::MODE_FADE_OUT;
            fade_cnt[v] = 0;
          end
        end
      end
      default: begin
        acc_l = 0;
        acc_r = 0;
        for (int v = 0; v < 4; v++)
          if (mode[v] != clp_pkg::MODE_OFF) mix_voice(v, acc_l, acc_r);
        f.left = sat24(acc_l);
        f.right = sat24(acc_r);
        frames_due.push_back(f);
      end
    endcase
  endfunction

  // Called once per accepted output transfer.
  function void check_frame(logic signed [23:0] l, logic signed [23:0] r);
    frame_t f;
    if (frames_due.size() == 0) begin
      $display("%0t: unexpected frame, expected none, actual %0d %0d", $time, l, r);
      errors++;
      return;
    end
    f = frames_due.pop_front();
    if (l !== f.left) begin
      $display("%0t: out_left mismatch, expected %0d, actual %0d", $time, f.left, l);
      errors++;
    end
    if (r !== f.right) begin
      $display("%0t: out_right mismatch, expected %0d, actual %0d", $time, f.right, r);
      errors++;
    end
  endfunction
endclass

module crossfading_loop_player_unit_tb;
  import clp_pkg::*;

  localparam int CYCLE_LIMIT = 8000000;
  localparam int LOW_BASE = 0;
  localparam int HIGH_BASE = 65472;

  logic clk = 0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] operation;
  logic [15:0] address;
  logic signed [23:0] write_left;
  logic signed [23:0] write_right;
  logic [1:0] voice_index;
  logic [15:0] range_a;
  logic [15:0] range_b;
  logic play_on;
  logic out_valid;
  logic out_stall;
  logic signed [23:0] out_left;
  logic signed [23:0] out_right;
  logic cfg_write;
  logic cfg_index;
  logic [15:0] cfg_data;

  loop_mix_scoreboard mix_sb = new();
  bit quiet = 0;
  int stall_left = 0;
  int cycles = 0;

  crossfading_loop_player_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .address(address),
    .write_left(write_left), .write_right(write_right),
    .voice_index(voice_index), .range_a(range_a), .range_b(range_b),
    .play_on(play_on),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_left(out_left), .out_right(out_right),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output side: check each frame transfer and stall in random bursts.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) mix_sb.check_frame(out_left, out_right);
    if (quiet) stall_left = 0;
    else if (stall_left > 0) stall_left--;
    else if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 18);
    out_stall <= (stall_left != 0);
  end

  task automatic send(logic [1:0] op, logic [15:0] addr, logic signed [23:0] wl,
                      logic signed [23:0] wr, logic [1:0] vi, logic [15:0] ra,
                      logic [15:0] rb, logic po);
    operation <= op;
    address <= addr;
    write_left <= wl;
    write_right <= wr;
    voice_index <= vi;
    range_a <= ra;
    range_b <= rb;
    play_on <= po;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    mix_sb.note_item(op, addr, wl, wr, vi, ra, rb, po);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic tick();
    send(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic set_range(logic [1:0] vi, logic [15:0] ra, logic [15:0] rb);
    send(OP_RANGE, $urandom, $urandom, $urandom, vi, ra, rb, $urandom);
  endtask

  task automatic pick(logic [1:0] vi, logic po);
    send(OP_SELECT, $urandom, $urandom, $urandom, vi, $urandom, $urandom, po);
  endtask

  task automatic ticks(int n);
    repeat (n) tick();
  endtask

  // Hold the sender until every frame has come back, then let the block settle.
  task automatic drain();
    in_valid <= 0;
    while (mix_sb.frames_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // The write enable drops again after each write.
  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    mix_sb.write_reg(idx, data);
    cfg_write <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      default: return $urandom;
    endcase
  endfunction

  // Loop bounds always stay inside one of the two preloaded blocks, or collapse
  // to an empty range that never reads memory.
  function automatic logic [15:0] rand_bound(int base);
    return base + $urandom_range(0, 63);
  endfunction

  task automatic rand_item();
    int sel;
    int base;
    logic [15:0] a;
    sel = $urandom_range(0, 99);
    base = $urandom_range(0, 1) ? HIGH_BASE : LOW_BASE;
    if (sel < 60) begin
      tick();
    end else if (sel < 75) begin
      if ($urandom_range(0, 9) == 0) a = $urandom;
      else a = rand_bound(base);
      send(OP_WRITE, a, rand_sample(), rand_sample(), $urandom, $urandom, $urandom,
           $urandom);
    end else if (sel < 85) begin
      if ($urandom_range(0, 7) == 0) begin
        a = $urandom;
        set_range($urandom, a, a);
      end else begin
        set_range($urandom, rand_bound(base), rand_bound(base));
      end
    end else begin
      pick($urandom, $urandom_range(0, 7) != 0);
    end
  endtask

  int unsigned phase_len[8] = '{1, 0, 31, 4095, 8, 2, 13, 5};
  int unsigned phase_gain[8] = '{65535, 0, 32768, 20000, 65535, 50000, 32768, 40000};

  initial begin
    rst <= 1;
    in_valid <= 0;
    operation <= OP_TICK;
    address <= 0;
    write_left <= 0;
    write_right <= 0;
    voice_index <= 0;
    range_a <= 0;
    range_b <= 0;
    play_on <= 0;
    cfg_write <= 0;
    cfg_index <= CFG_LEN;
    cfg_data <= 0;
    out_stall <= 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // Preload both memory blocks, then a few frames at the reset settings.
    for (int i = 0; i < 64; i++) begin
      send(OP_WRITE, LOW_BASE + i, rand_sample(), rand_sample(), 0, 0, 0, 0);
      send(OP_WRITE, HIGH_BASE + i, rand_sample(), rand_sample(), 0, 0, 0, 0);
    end
    ticks(2);
    drain();

    // Directed: fades, repeated and reversed selects, seams, swapped bounds.
    write_reg(CFG_LEN, 4);
    write_reg(CFG_GAIN, 32768);
    set_range(0, 0, 12);
    set_range(1, 65535, HIGH_BASE);
    set_range(2, 100, 100);
    pick(0, 1);
    ticks(3);
    pick(0, 1);
    pick(1, 1);
    ticks(2);
    pick(0, 1);
    ticks(16);
    pick(2, 1);
    ticks(2);
    pick(3, 0);
    ticks(6);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_LEN, phase_len[ph]);
      write_reg(CFG_GAIN, phase_gain[ph]);
      if (ph == 7) quiet = 1;
      for (int j = 0; j < 190; j++) rand_item();
      drain();
    end

    if (mix_sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
